// File: design/bdee_pkg.sv
`default_nettype none

package bdee_pkg;

   localparam int DEFAULT_MAX_STRIDE = 4;
   localparam int QDEPTH             = 4;

   localparam logic [1:0] MODE_RAW      = 2'd0;
   localparam logic [1:0] MODE_TEMPORAL = 2'd1;
   localparam logic [1:0] MODE_SPATIAL  = 2'd2;

   localparam logic CSR_MODE   = 1'b0;
   localparam logic CSR_STRIDE = 1'b1;

   localparam logic [2:0] STRIDE_RESET = 3'd1;

   localparam logic [3:0] CODE_LEN    = 4'd4;
   localparam logic [3:0] ESC_LEN     = 4'd12;
   localparam logic [3:0] DELTA_BIAS  = 4'd7;
   localparam logic [3:0] ESCAPE_CODE = 4'd15;

   typedef struct packed {
      logic [7:0] cur_byte;
      logic [7:0] prev_frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] channel_stride;
   } cfg_type;

   // up to three result bytes produced by one transaction
   typedef struct packed {
      logic [1:0]        count;
      rsp_type [2:0]     item;
   } push_type;

endpackage

`default_nettype wire

// File: design/byte_delta_escape_encoder.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_ready     req_item  (cur_byte, prev_frame_byte, frame_end)
// rsp_      out        rsp_valid / rsp_ready     rsp_item  (out_byte, out_last)
// csr_      in         csr_wen                   csr_index, csr_wdata (3 bits)
//
// A transaction is held in the input register, is encoded in one pass into
// a four-entry result queue, and its first byte shows on rsp_ from the registered queue head.
// One transaction is taken per cycle while the queue has room for its 0..3 bytes;
// the queue drains one byte per cycle while rsp_ready is high, so rsp_ sets the sustained rate.
// Synchronous reset clears the packer, history, byte count, queue and registers.
// A stall on rsp_ backs up the queue, then the input register, then req_ready.

module byte_delta_escape_encoder #(
   parameter int MAX_STRIDE = bdee_pkg::DEFAULT_MAX_STRIDE
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  bdee_pkg::req_type    req_item,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output bdee_pkg::rsp_type    rsp_item,
   input  wire                  csr_wen,
   input  wire                  csr_index,
   input  wire [2:0]            csr_wdata
);
   import bdee_pkg::*;

   logic [1:0] mode_ff;
   logic [2:0] stride_ff;
   cfg_type    cfg;
   logic       item_valid;
   req_type    item;
   logic       take;
   push_type   push;

   // configuration registers: to be written only while idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RAW;
         stride_ff <= STRIDE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wdata[1:0];
            CSR_STRIDE: stride_ff <= csr_wdata;
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   assign cfg.mode           = mode_ff;
   assign cfg.channel_stride = stride_ff;

   // input register: holds one transaction until the queue can take its bytes
   bdee_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // delta / escape coding, bit packing, history and frame byte count
   bdee_encoder #(
      .MAX_STRIDE (MAX_STRIDE)
   ) u_encoder (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .item  (item),
      .take  (take),
      .push  (push)
   );

   // result queue: decides when the encoded transaction is taken
   bdee_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .push       (push),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// File: design/bdee_in_stage.sv
`default_nettype none

module bdee_in_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  bdee_pkg::req_type    req_item,
   input  wire                  take,
   output logic                 item_valid,
   output bdee_pkg::req_type    item
);
   import bdee_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

// File: design/bdee_encoder.sv
`default_nettype none

module bdee_encoder #(
   parameter int MAX_STRIDE = bdee_pkg::DEFAULT_MAX_STRIDE
) (
   input  wire                  clock,
   input  wire                  reset,
   input  bdee_pkg::cfg_type    cfg,
   input  bdee_pkg::req_type    item,
   input  wire                  take,
   output bdee_pkg::push_type   push
);
   import bdee_pkg::*;

   localparam int HDR_W = $clog2(MAX_STRIDE + 1);
   localparam int IDX_W = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;

   logic [6:0]       acc_ff, acc_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [HDR_W-1:0] hdr_ff, hdr_in;
   logic [7:0]       hist_ff [MAX_STRIDE];

   logic [3:0]        stride;
   logic [7:0]        ref_byte;
   logic              use_delta;
   logic signed [8:0] diff;
   logic [11:0]       sym;
   logic [3:0]        sym_len;
   logic [23:0]       word;
   logic [4:0]        total;
   logic [6:0]        rem;
   logic [2:0]        rem_cnt;
   logic [1:0]        n;
   logic [7:0]        slot [3];

   always_comb begin
      stride = {1'b0, cfg.channel_stride};
      if (stride == 4'd0) begin
         stride = 4'd1;
      end else if (stride > 4'(MAX_STRIDE)) begin
         stride = 4'(MAX_STRIDE);
      end
   end

   always_comb begin
      use_delta = (cfg.mode == MODE_TEMPORAL) ||
                  ((cfg.mode == MODE_SPATIAL) && (4'(hdr_ff) >= stride));
      ref_byte  = (cfg.mode == MODE_TEMPORAL) ? item.prev_frame_byte
                                             : hist_ff[IDX_W'(stride - 4'd1)];
      diff      = $signed({1'b0, item.cur_byte}) - $signed({1'b0, ref_byte});
      if ((diff >= -9'sd7) && (diff <= 9'sd7)) begin
         sym     = {8'd0, diff[3:0] + DELTA_BIAS};
         sym_len = CODE_LEN;
      end else begin
         sym     = {item.cur_byte, ESCAPE_CODE};
         sym_len = ESC_LEN;
      end
      word  = {17'd0, acc_ff} | ({12'd0, sym} << cnt_ff);
      total = {2'd0, cnt_ff} + {1'b0, sym_len};
   end

   always_comb begin
      slot[0] = 8'd0;
      slot[1] = 8'd0;
      slot[2] = 8'd0;
      if (use_delta) begin
         n       = total[4:3];
         rem_cnt = total[2:0];
         slot[0] = word[7:0];
         slot[1] = word[15:8];
         case (n)
            2'd0:    rem = word[6:0];
            2'd1:    rem = word[14:8];
            default: rem = word[22:16];
         endcase
      end else begin
         rem     = 7'd0;
         rem_cnt = 3'd0;
         if (cnt_ff != 3'd0) begin
            n       = 2'd2;
            slot[0] = {1'b0, acc_ff};
            slot[1] = item.cur_byte;
         end else begin
            n       = 2'd1;
            slot[0] = item.cur_byte;
         end
      end
      // frame end flushes the zero-padded remainder
      if (item.frame_end && (rem_cnt != 3'd0)) begin
         case (n)
            2'd0:    slot[0] = {1'b0, rem};
            2'd1:    slot[1] = {1'b0, rem};
            default: slot[2] = {1'b0, rem};
         endcase
         n = n + 2'd1;
      end
   end

   always_comb begin
      push.count = n;
      for (int k = 0; k < 3; k++) begin
         push.item[k].out_byte = slot[k];
         push.item[k].out_last = item.frame_end && ((2'(k) + 2'd1) == n);
      end
   end

   always_comb begin
      if (item.frame_end) begin
         acc_in = 7'd0;
         cnt_in = 3'd0;
         hdr_in = '0;
      end else begin
         acc_in = rem;
         cnt_in = rem_cnt;
         hdr_in = (hdr_ff < HDR_W'(MAX_STRIDE)) ? hdr_ff + HDR_W'(1) : hdr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 7'd0;
         cnt_ff <= 3'd0;
         hdr_ff <= '0;
         for (int i = 0; i < MAX_STRIDE; i++) begin
            hist_ff[i] <= 8'd0;
         end
      end else if (take) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         hdr_ff <= hdr_in;
         for (int i = MAX_STRIDE - 1; i > 0; i--) begin
            hist_ff[i] <= hist_ff[i-1];
         end
         hist_ff[0] <= item.cur_byte;
      end
   end

endmodule

`default_nettype wire

// File: design/bdee_out_queue.sv
`default_nettype none

module bdee_out_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  item_valid,
   input  bdee_pkg::push_type   push,
   output logic                 take,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output bdee_pkg::rsp_type    rsp_item
);
   import bdee_pkg::*;

   localparam int CNT_W = $clog2(QDEPTH + 1);

   rsp_type          q_ff [QDEPTH];
   rsp_type          q_in [QDEPTH];
   logic [CNT_W-1:0] count_ff, count_in, level;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = q_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign level     = count_ff - CNT_W'(pop);
   assign take      = item_valid &&
                      (({1'b0, level} + (CNT_W+1)'(push.count)) <= (CNT_W+1)'(QDEPTH));
   assign count_in  = level + (take ? CNT_W'(push.count) : '0);

   always_comb begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_in[i] = (pop && (i + 1 < QDEPTH)) ? q_ff[(i + 1) % QDEPTH] : q_ff[i];
         if (take && (i >= int'(level)) && (i < int'(level) + int'(push.count))) begin
            q_in[i] = push.item[2'(i - int'(level))];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

`default_nettype wire

// File: tb/sv/tb_byte_delta_escape_encoder.sv
`timescale 1ns / 1ps

module tb_byte_delta_escape_encoder;
   import bdee_pkg::*;

   localparam int HIST_DEPTH = DEFAULT_MAX_STRIDE;
   localparam int BYTE_BITS  = 8;
   localparam int SETTLE     = 8;   // input register plus encode pass, with margin
   localparam int RAND_PHASES = 7;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;
   logic    csr_wen   = 1'b0;
   logic    csr_index = CSR_MODE;
   logic [2:0] csr_wdata = 3'd0;

   byte_delta_escape_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------------
   // Stimulus queue, expected output bytes and run statistics
   // ---------------------------------------------------------------------
   req_type     pending_bytes[$];
   rsp_type     expected_bytes[$];
   int unsigned fail_count    = 0;
   int unsigned queued_items  = 0;
   int unsigned accepted_items = 0;
   int unsigned checked_bytes = 0;
   int unsigned frame_ends    = 0;
   int unsigned escapes_seen  = 0;

   // ---------------------------------------------------------------------
   // Encoder prediction: our own copy of the registers, the bit packer,
   // the byte history and the per-frame byte count.
   // ---------------------------------------------------------------------
   logic [1:0] cfg_mode   = MODE_RAW;
   logic [2:0] cfg_stride = STRIDE_RESET;
   logic [6:0] pend_bits  = '0;
   logic [2:0] pend_count = '0;
   logic [7:0] byte_hist [HIST_DEPTH];
   logic [2:0] frame_seen = '0;
   rsp_type    step_bytes[$];   // bytes produced by the transaction in hand

   // stimulus side keeps its own history so spatial deltas can be aimed small
   logic [7:0] src_hist [HIST_DEPTH];

   initial begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
         byte_hist[k] = '0;
         src_hist[k]  = '0;
      end
   end

   // stride 0 behaves as 1, anything above the history depth as the depth
   function automatic int unsigned eff_stride();
      if (cfg_stride == 3'd0)
         return 1;
      if (cfg_stride > HIST_DEPTH)
         return HIST_DEPTH;
      return cfg_stride;
   endfunction

   function void emit_byte(logic [7:0] value);
      rsp_type r;
      r.out_byte = value;
      r.out_last = 1'b0;
      step_bytes.push_back(r);
   endfunction

   // append width bits LSB first, emitting every completed byte
   function void push_code(logic [7:0] bits, int unsigned width);
      logic [15:0] word;
      int unsigned total;
      word  = 16'(pend_bits) | (16'(bits) << pend_count);
      total = pend_count + width;
      while (total >= BYTE_BITS) begin
         emit_byte(word[7:0]);
         word  = word >> BYTE_BITS;
         total = total - BYTE_BITS;
      end
      pend_bits  = word[6:0];
      pend_count = 3'(total);
   endfunction

   function void flush_pending();
      if (pend_count != 3'd0) begin
         emit_byte({1'b0, pend_bits});
         pend_bits  = '0;
         pend_count = '0;
      end
   endfunction

   function void code_delta(logic [7:0] cur, logic [7:0] anchor);
      int diff;
      diff = int'(cur) - int'(anchor);
      if (diff >= -int'(DELTA_BIAS) && diff <= int'(DELTA_BIAS)) begin
         push_code(8'(diff + int'(DELTA_BIAS)), CODE_LEN);
      end else begin
         push_code(8'(ESCAPE_CODE), CODE_LEN);
         push_code(cur, BYTE_BITS);
         escapes_seen++;
      end
   endfunction

   // Work out the output bytes of one accepted transaction and queue them.
   function void encode_item(req_type it);
      int unsigned stride;
      stride = eff_stride();
      step_bytes.delete();
      if (cfg_mode == MODE_TEMPORAL) begin
         code_delta(it.cur_byte, it.prev_frame_byte);
      end else if (cfg_mode == MODE_SPATIAL && frame_seen >= stride) begin
         code_delta(it.cur_byte, byte_hist[stride - 1]);
      end else begin
         // raw path (also mode 3 and spatial header bytes): byte-aligned
         flush_pending();
         emit_byte(it.cur_byte);
      end
      for (int k = HIST_DEPTH - 1; k > 0; k--)
         byte_hist[k] = byte_hist[k - 1];
      byte_hist[0] = it.cur_byte;
      if (frame_seen < HIST_DEPTH)
         frame_seen++;
      if (it.frame_end) begin
         flush_pending();
         frame_seen = '0;
         if (step_bytes.size() != 0)
            step_bytes[step_bytes.size() - 1].out_last = 1'b1;
      end
      foreach (step_bytes[k])
         expected_bytes.push_back(step_bytes[k]);
   endfunction

   // ---------------------------------------------------------------------
   // Idle draws: a random gap per transaction, with calm stretches of none
   // ---------------------------------------------------------------------
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   function automatic int unsigned draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued items; the gap drawn on loading an item is
   // spent after that item's transaction completes.
   // ---------------------------------------------------------------------
   int unsigned send_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && req_ready) begin
            encode_item(req_item);
            accepted_items++;
         end
         if (req_valid && !req_ready) begin
            // hold payload until taken
         end else if (send_wait != 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (pending_bytes.size() != 0) begin
            req_item  <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            send_wait <= draw_gap(tx_calm);
            if ($urandom_range(0, 15) == 0)
               tx_calm = !tx_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each output transaction against the oldest expected
   // byte, then draws a stall before accepting the next one.
   // ---------------------------------------------------------------------
   int unsigned recv_wait = 0;

   always @(posedge clock) begin : rsp_side
      rsp_type     want;
      int unsigned gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte %h (out_last %b) arrived with nothing expected",
                   rsp_item.out_byte, rsp_item.out_last);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            checked_bytes++;
            if (rsp_item.out_byte !== want.out_byte) begin
               $error("out_byte mismatch: expected %h, got %h",
                      want.out_byte, rsp_item.out_byte);
               fail_count++;
            end
            if (rsp_item.out_last !== want.out_last) begin
               $error("out_last mismatch: expected %b, got %b",
                      want.out_last, rsp_item.out_last);
               fail_count++;
            end
         end
         gap = draw_gap(rx_calm);
         if ($urandom_range(0, 15) == 0)
            rx_calm = !rx_calm;
         recv_wait <= gap;
         rsp_ready <= (gap == 0);
      end else if (recv_wait != 0) begin
         recv_wait <= recv_wait - 1;
         rsp_ready <= (recv_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function void add_item(logic [7:0] cur, logic [7:0] prev, bit last);
      req_type it;
      it.cur_byte        = cur;
      it.prev_frame_byte = prev;
      it.frame_end       = last;
      pending_bytes.push_back(it);
      for (int k = HIST_DEPTH - 1; k > 0; k--)
         src_hist[k] = src_hist[k - 1];
      src_hist[0] = cur;
      queued_items++;
      if (last)
         frame_ends++;
   endfunction

   // Mostly small deltas from the byte the current mode codes against,
   // some on the escape boundary, the rest fully random.
   function void add_random_item(bit last);
      int          diff;
      int unsigned pick;
      logic [7:0]  prev;
      logic [7:0]  anchor;
      pick = $urandom_range(0, 9);
      prev = 8'($urandom_range(0, 255));
      if (pick < 6)
         diff = int'($urandom_range(0, 14)) - int'(DELTA_BIAS);
      else if (pick < 8)
         diff = ($urandom_range(0, 1) ? 8 : 7) * ($urandom_range(0, 1) ? 1 : -1);
      else
         diff = int'($urandom_range(0, 255));
      anchor = (cfg_mode == MODE_SPATIAL) ? src_hist[eff_stride() - 1] : prev;
      add_item((pick < 8) ? 8'(int'(anchor) + diff) : 8'(diff), prev, last);
   endfunction

   // register writes happen only with the encoder idle
   task automatic apply_config(logic [1:0] mode_val, logic [2:0] stride_val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= {1'b0, mode_val};
      @(posedge clock);
      csr_index <= CSR_STRIDE;
      csr_wdata <= stride_val;
      @(posedge clock);
      csr_wen   <= 1'b0;
      cfg_mode   = mode_val;
      cfg_stride = stride_val;
   endtask

   // wait for every transaction and every expected byte, then let any
   // transaction that produced no byte clear the pipeline
   task automatic drain();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : sequence_main
      int unsigned frame_left;
      int unsigned n_items;
      int unsigned pick;
      logic [1:0]  mode_val;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: raw, both byte extremes, frame end on a raw byte
      add_item(8'h00, 8'hFF, 1'b0);
      add_item(8'hFF, 8'h00, 1'b1);
      drain();

      // temporal: both delta limits, zero, just past each limit, full-scale
      // swings; frame left open with a nibble still pending
      apply_config(MODE_TEMPORAL, 3'd4);
      add_item(8'h10, 8'h17, 1'b0);
      add_item(8'h17, 8'h10, 1'b0);
      add_item(8'h40, 8'h40, 1'b0);
      add_item(8'h20, 8'h28, 1'b0);
      add_item(8'h28, 8'h20, 1'b0);
      add_item(8'h00, 8'hFF, 1'b0);
      add_item(8'hFF, 8'h00, 1'b0);
      add_item(8'h55, 8'h54, 1'b0);
      add_item(8'hAA, 8'hAB, 1'b0);
      drain();

      // mode change inside the frame: raw byte must flush the pending nibble
      apply_config(MODE_RAW, 3'd4);
      add_item(8'h3C, 8'h00, 1'b0);
      drain();

      // unused mode value 3 falls back to raw
      apply_config(2'd3, 3'd4);
      add_item(8'hC3, 8'h11, 1'b1);
      drain();

      // spatial, stride 2: two raw header bytes, then deltas and an escape
      apply_config(MODE_SPATIAL, 3'd2);
      add_item(8'h10, 8'h00, 1'b0);
      add_item(8'h80, 8'h00, 1'b0);
      add_item(8'h13, 8'h00, 1'b0);
      add_item(8'h7A, 8'h00, 1'b0);
      add_item(8'h90, 8'h00, 1'b0);
      add_item(8'h7B, 8'h00, 1'b1);
      drain();

      // stride 0 acts as 1; frame end flushes a half byte with out_last
      apply_config(MODE_SPATIAL, 3'd0);
      add_item(8'h05, 8'h00, 1'b0);
      add_item(8'h06, 8'h00, 1'b1);
      drain();

      // stride 7 clamps to the history depth
      apply_config(MODE_SPATIAL, 3'd7);
      add_item(8'h01, 8'h00, 1'b0);
      add_item(8'h02, 8'h00, 1'b0);
      add_item(8'h03, 8'h00, 1'b0);
      add_item(8'h04, 8'h00, 1'b0);
      add_item(8'h03, 8'h00, 1'b1);
      drain();

      // Random phases: frames of 1..12 bytes with mostly codable deltas.
      // Frames run across phase boundaries, so mode and stride change
      // inside frames as well.
      frame_left = 0;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         pick = $urandom_range(0, 5);
         case (pick)
            0:       mode_val = MODE_RAW;
            1, 4:    mode_val = MODE_TEMPORAL;
            2, 5:    mode_val = MODE_SPATIAL;
            default: mode_val = 2'd3;
         endcase
         apply_config(mode_val, 3'($urandom_range(0, 7)));
         n_items = $urandom_range(24, 30);
         for (int k = 0; k < n_items; k++) begin
            if (frame_left == 0)
               frame_left = $urandom_range(1, 12);
            add_random_item(frame_left == 1);
            frame_left--;
         end
         drain();
      end

      $display("Queued %0d, encoded %0d transactions in %0d frame ends, checked %0d bytes",
               queued_items, accepted_items, frame_ends, checked_bytes);
      $display("Escapes coded: %0d; modes raw, temporal, spatial and unused; strides 0..7",
               escapes_seen);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin : watchdog
      #(2_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule

// File: byte_delta_escape_encoder.f
design/bdee_pkg.sv
design/bdee_in_stage.sv
design/bdee_encoder.sv
design/bdee_out_queue.sv
design/byte_delta_escape_encoder.sv
tb/sv/tb_byte_delta_escape_encoder.sv
